[rtl/scf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scf_pkg
// Shared types, widths and character codes for the serial command framer.
// ----------------------------------------------------------------------------
package scf_pkg;

   localparam int SLOT_SIZE = 64;                 // line store entries per link
   localparam int PTR_W     = $clog2(SLOT_SIZE);  // index inside one slot
   localparam int ADDR_W    = PTR_W + 1;          // link bit on top
   localparam int CNT_W     = PTR_W + 1;          // fill count, holds SLOT_SIZE

   localparam logic [7:0] ACK_BYTE   = 8'h06;
   localparam logic [7:0] HASH_BYTE  = 8'h23;
   localparam logic [7:0] CR_BYTE    = 8'h0D;
   localparam logic [7:0] LF_BYTE    = 8'h0A;
   localparam logic [7:0] COLON_BYTE = 8'h3A;
   localparam logic [7:0] SPACE_BYTE = 8'h20;
   localparam logic [7:0] TAB_BYTE   = 8'h09;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD
   } scf_state_type;

   // what one accepted byte asks of the datapath
   typedef struct packed {
      logic             ack;     // answer with an acknowledge query beat
      logic             store;   // write the byte into the line store
      logic             emit;    // drain a span of the line store
      logic [PTR_W-1:0] wr_ptr;  // slot entry for the write
      logic [PTR_W-1:0] from;    // first entry of the span
      logic [CNT_W-1:0] to;      // one past the last entry of the span
   } scf_act_type;

   // space, tab, LF, VT, FF, CR
   function automatic logic is_blank(input logic [7:0] b);
      is_blank = (b == SPACE_BYTE) || ((b >= TAB_BYTE) && (b <= CR_BYTE));
   endfunction

endpackage : scf_pkg
`default_nettype wire

[rtl/scf_chan_track.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scf_chan_track
// Per-link line bookkeeping: fill count, leading-blank count, trimmed end and
// colon flag. Decodes each byte into an action for the datapath.
// ----------------------------------------------------------------------------
module scf_chan_track #(
   parameter int MAX_CMD_BYTES = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic                channel,
   input  wire logic [7:0]          rx_byte,
   output scf_pkg::scf_act_type     act
);
   import scf_pkg::*;

   logic [CNT_W-1:0] fill_ff [2];
   logic [CNT_W-1:0] fill_in [2];
   logic [CNT_W-1:0] lead_ff [2];   // leading blanks so far
   logic [CNT_W-1:0] lead_in [2];
   logic [CNT_W-1:0] tail_ff [2];   // end of line after trailing-blank trim
   logic [CNT_W-1:0] tail_in [2];
   logic             colon_ff [2];
   logic             colon_in [2];

   logic [CNT_W-1:0] n;
   logic [CNT_W-1:0] n_inc;
   logic             blank;
   logic             eol;
   logic             ovf;
   logic             hash;
   logic             ack;

   assign n     = fill_ff[channel];
   assign n_inc = n + CNT_W'(1);
   assign blank = is_blank(rx_byte);
   assign eol   = (rx_byte == CR_BYTE) || (rx_byte == LF_BYTE);
   assign ovf   = n >= CNT_W'(MAX_CMD_BYTES);
   assign hash  = rx_byte == HASH_BYTE;
   assign ack   = (rx_byte == ACK_BYTE) && (n == '0);

   always_comb begin
      act.ack    = ack;
      act.store  = !ack && !eol && !ovf;
      act.wr_ptr = n[PTR_W-1:0];
      act.emit   = 1'b0;
      act.from   = '0;
      act.to     = n;
      priority if (ack) begin
         act.emit = 1'b0;
      end else if (eol) begin
         act.emit = (n != '0) && colon_ff[channel];
         act.to   = tail_ff[channel];
      end else if (!ovf && hash) begin
         act.emit = lead_ff[channel] < n;
         act.from = lead_ff[channel][PTR_W-1:0];
      end else begin
         act.emit = 1'b0;
      end
   end

   always_comb begin
      fill_in  = fill_ff;
      lead_in  = lead_ff;
      tail_in  = tail_ff;
      colon_in = colon_ff;
      if (accept && !ack) begin
         if (eol || ovf || hash) begin
            fill_in[channel]  = '0;
            lead_in[channel]  = '0;
            tail_in[channel]  = '0;
            colon_in[channel] = 1'b0;
         end else begin
            fill_in[channel] = n_inc;
            if (n == '0) begin
               colon_in[channel] = rx_byte == COLON_BYTE;
            end
            if (blank && (lead_ff[channel] == n)) begin
               lead_in[channel] = n_inc;
            end
            if (!blank) begin
               tail_in[channel] = n_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '{default: '0};
         lead_ff  <= '{default: '0};
         tail_ff  <= '{default: '0};
         colon_ff <= '{default: 1'b0};
      end else begin
         fill_ff  <= fill_in;
         lead_ff  <= lead_in;
         tail_ff  <= tail_in;
         colon_ff <= colon_in;
      end
   end

endmodule : scf_chan_track
`default_nettype wire

[rtl/serial_command_framer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// serial_command_framer
// Two-link command framer: buffers bytes per link and streams framed commands.
// ----------------------------------------------------------------------------
// Input beats carry one received byte and its link. Ordinary bytes are stored
// in a 128 x 8 line store (64 entries per link) and take one cycle each. A lone
// 0x06 on an empty link gives a single acknowledge query beat. CR or LF closes
// a line: a line starting with ':' is streamed with trailing blanks trimmed.
// '#' closes a command: leading blanks are dropped, the '#' is not sent, and
// the last beat carries tlast. Overflow past MAX_CMD_BYTES clears the link.
// While a command drains, req_tready is low; each output beat takes a line
// store read (ST_READ), then an output register load (ST_LOAD), so a command
// holds the input for its whole drain plus receiver stalls. Input is also
// held while a finished beat waits in the output register and is not being
// taken. A stalled receiver simply freezes the drain; nothing is dropped.
// Reset clears the per-link counts; the line store itself is not cleared and
// needs no clearing pass, since only written entries are ever read.
// ----------------------------------------------------------------------------
module serial_command_framer #(
   parameter int MAX_CMD_BYTES = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] rx_byte
   input  wire logic       req_tuser,   // [0] channel
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] cmd_byte
   output logic [1:0]      rsp_tuser,   // [0] out_channel, [1] is_ack_query
   output logic            rsp_tlast
);
   import scf_pkg::*;

   logic             accept;
   scf_act_type      act;

   scf_state_type    st_ff;
   scf_state_type    st_in;
   logic             ch_ff;
   logic [PTR_W-1:0] idx_ff;
   logic [CNT_W-1:0] end_ff;

   logic [7:0]       line_mem [2 * SLOT_SIZE];
   logic [7:0]       rd_data_ff;

   logic             rsp_valid_ff;
   logic             rsp_ch_ff;
   logic             rsp_ack_ff;
   logic [7:0]       rsp_byte_ff;
   logic             rsp_last_ff;

   logic             out_free;
   logic             ram_rd_en;
   logic             ld_ram;
   logic             emit_last;

   assign accept    = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign emit_last = ({1'b0, idx_ff} + CNT_W'(1)) == end_ff;

   scf_chan_track #(
      .MAX_CMD_BYTES(MAX_CMD_BYTES)
   ) u_track (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .channel (req_tuser),
      .rx_byte (req_tdata),
      .act     (act)
   );

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (accept && act.emit) st_in = ST_READ;
         ST_READ: if (out_free) st_in = ST_LOAD;
         ST_LOAD: st_in = emit_last ? ST_IDLE : ST_READ;
         default: st_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      ram_rd_en  = 1'b0;
      ld_ram     = 1'b0;
      unique case (st_ff)
         ST_IDLE: req_tready = out_free;
         ST_READ: ram_rd_en  = out_free;
         ST_LOAD: ld_ram     = 1'b1;
         default: req_tready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ch_ff  <= req_tuser;
         idx_ff <= act.from;
         end_ff <= act.to;
      end else if (ld_ram) begin
         idx_ff <= idx_ff + PTR_W'(1);
      end
   end

   // line store
   always_ff @(posedge clock) begin
      if (accept && act.store) begin
         line_mem[{req_tuser, act.wr_ptr}] <= req_tdata;
      end
      if (ram_rd_en) begin
         rd_data_ff <= line_mem[{ch_ff, idx_ff}];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((accept && act.ack) || ld_ram) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && act.ack) begin
         rsp_ch_ff   <= req_tuser;
         rsp_ack_ff  <= 1'b1;
         rsp_byte_ff <= ACK_BYTE;
         rsp_last_ff <= 1'b1;
      end else if (ld_ram) begin
         rsp_ch_ff   <= ch_ff;
         rsp_ack_ff  <= 1'b0;
         rsp_byte_ff <= rd_data_ff;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = {rsp_ack_ff, rsp_ch_ff};
   assign rsp_tlast  = rsp_last_ff;

   // a read result always lands in an empty output register
   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_LOAD |-> !rsp_valid_ff)
      else $error("line store data would overwrite a pending beat");

   // a drain starts with a non-empty span
   a_span_nonempty: assert property (@(posedge clock) disable iff (reset)
      (accept && act.emit) |=> ({1'b0, idx_ff} < end_ff))
      else $error("empty span started");

   // the read pointer never passes the span end
   a_read_in_span: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_READ |-> ({1'b0, idx_ff} < end_ff))
      else $error("read beyond span end");

   // an acknowledge query is always a single closing 0x06 beat
   a_ack_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ack_ff) |-> (rsp_last_ff && (rsp_byte_ff == ACK_BYTE)))
      else $error("malformed acknowledge query beat");

endmodule : serial_command_framer
`default_nettype wire

[dv/tb_serial_command_framer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_command_framer
// Self-checking bench for the two-link command framer. Bytes are streamed in
// on both links, and a scoreboard keeps its own per-link line buffers. From
// them it works out the acknowledge query, line and '#' command beats, and it
// checks every output beat in order. Both sides of the stream stall at random.
// ----------------------------------------------------------------------------
import scf_pkg::*;

typedef struct packed {
   logic       ch;
   logic       ack;
   logic [7:0] data;
   logic       last;
} framed_beat_type;

class cmd_scoreboard;
   logic [7:0]      slot_mem [2][SLOT_SIZE];
   int              fill [2];
   int              max_bytes;
   int              mismatches;
   framed_beat_type expected_beats [$];

   function new(int max_cmd);
      max_bytes  = max_cmd;
      mismatches = 0;
      fill[0]    = 0;
      fill[1]    = 0;
   endfunction

   function bit blank_char(logic [7:0] b);
      return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function int pending();
      return expected_beats.size();
   endfunction

   function void queue_span(bit ch, int from, int to);
      framed_beat_type bt;
      for (int i = from; i < to; i++) begin
         bt.ch   = ch;
         bt.ack  = 1'b0;
         bt.data = slot_mem[ch][i];
         bt.last = (i + 1 == to);
         expected_beats.push_back(bt);
      end
   endfunction

   // one accepted input beat
   function void note_byte(bit ch, logic [7:0] b);
      int n;
      int lo;
      int hi;
      framed_beat_type bt;
      n = fill[ch];
      if (b == ACK_BYTE && n == 0) begin
         bt = '{ch, 1'b1, ACK_BYTE, 1'b1};
         expected_beats.push_back(bt);
         return;
      end
      if (b == CR_BYTE || b == LF_BYTE) begin
         fill[ch] = 0;
         if (n == 0 || slot_mem[ch][0] != COLON_BYTE) return;
         hi = n;
         while (hi > 0 && blank_char(slot_mem[ch][hi-1])) hi--;
         queue_span(ch, 0, hi);
         return;
      end
      // full buffer: the byte is dropped along with the buffer, even a '#'
      if (n >= max_bytes) begin
         fill[ch] = 0;
         return;
      end
      slot_mem[ch][n] = b;
      n++;
      if (b != HASH_BYTE) begin
         fill[ch] = n;
         return;
      end
      fill[ch] = 0;
      hi = n - 1;
      lo = 0;
      while (lo < hi && blank_char(slot_mem[ch][lo])) lo++;
      if (lo < hi) queue_span(ch, lo, hi);
   endfunction

   function void flag(string what, framed_beat_type want, framed_beat_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s: expected ch=%0d ack=%0d byte=%02h last=%0d, %s",
                  $time, what, want.ch, want.ack, want.data, want.last,
                  $sformatf("got ch=%0d ack=%0d byte=%02h last=%0d",
                            got.ch, got.ack, got.data, got.last));
   endfunction

   function void check_beat(framed_beat_type got);
      framed_beat_type want;
      if (expected_beats.size() == 0) begin
         flag("unexpected beat", got, got);
         return;
      end
      want = expected_beats.pop_front();
      if (want != got) flag("beat mismatch", want, got);
   endfunction
endclass

module tb_serial_command_framer;

   localparam int MAX_BYTES = 64;

   typedef enum {
      K_ACK,
      K_LINE,
      K_CMD,
      K_NOISE,
      K_LONG_LINE,
      K_OVERFLOW
   } frame_kind_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;    // [7:0] rx_byte
   logic       req_tuser;    // [0] channel
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;    // [7:0] cmd_byte
   logic [1:0] rsp_tuser;    // [0] out_channel, [1] is_ack_query
   logic       rsp_tlast;

   cmd_scoreboard sb;
   int            snd_idle_pct;
   int            rcv_idle_pct;
   int            items_sent;
   logic [7:0]    pend0 [$];
   logic [7:0]    pend1 [$];

   serial_command_framer #(
      .MAX_CMD_BYTES(MAX_BYTES)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("Verification failed");
      $finish;
   end

   // receiver back-pressure
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_beat({rsp_tuser[0], rsp_tuser[1], rsp_tdata, rsp_tlast});
   end

   task automatic send_byte(bit ch, logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = b;
      req_tuser  = ch;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(ch, b);
      items_sent++;
   endtask

   task automatic send_text(bit ch, string s);
      for (int i = 0; i < s.len(); i++) send_byte(ch, s[i]);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [7:0] body_byte();
      logic [7:0] b;
      do begin
         if ($urandom_range(3) != 0) b = $urandom_range(8'h7E, 8'h21);
         else b = $urandom_range(255);
      end while (b == CR_BYTE || b == LF_BYTE || b == HASH_BYTE);
      return b;
   endfunction

   // blanks that do not end a line
   function automatic logic [7:0] blank_byte();
      case ($urandom_range(3))
         0: return SPACE_BYTE;
         1: return TAB_BYTE;
         2: return 8'h0B;
         default: return 8'h0C;
      endcase
   endfunction

   function automatic frame_kind_type rand_kind();
      int r;
      r = $urandom_range(99);
      if (r < 15) return K_ACK;
      if (r < 45) return K_LINE;
      if (r < 80) return K_CMD;
      return K_NOISE;
   endfunction

   task automatic add_seq(bit ch, frame_kind_type k);
      logic [7:0] s [$];
      case (k)
         K_ACK: s.push_back(ACK_BYTE);
         K_LINE: begin
            // mostly well-formed; now and then the colon is missing
            if ($urandom_range(7) != 0) s.push_back(COLON_BYTE);
            repeat ($urandom_range(6)) s.push_back(body_byte());
            repeat ($urandom_range(2)) s.push_back(blank_byte());
            s.push_back($urandom_range(1) ? CR_BYTE : LF_BYTE);
         end
         K_CMD: begin
            repeat ($urandom_range(2)) s.push_back(blank_byte());
            repeat ($urandom_range(6)) s.push_back(body_byte());
            repeat ($urandom_range(1)) s.push_back(blank_byte());
            s.push_back(HASH_BYTE);
         end
         K_NOISE: repeat ($urandom_range(3, 1)) s.push_back($urandom_range(255));
         K_LONG_LINE: begin
            s.push_back(COLON_BYTE);
            repeat (MAX_BYTES - 1) s.push_back(body_byte());
            s.push_back(CR_BYTE);
         end
         K_OVERFLOW: begin
            repeat (MAX_BYTES) s.push_back(body_byte());
            s.push_back(HASH_BYTE);
         end
         default: ;
      endcase
      foreach (s[i]) begin
         if (ch) pend1.push_back(s[i]);
         else pend0.push_back(s[i]);
      end
   endtask

   // interleave the two links beat by beat
   task automatic flush_pending();
      logic [7:0] b;
      while (pend0.size() + pend1.size() > 0) begin
         if (pend1.size() == 0 || (pend0.size() != 0 && $urandom_range(1) == 0)) begin
            b = pend0.pop_front();
            send_byte(1'b0, b);
         end else begin
            b = pend1.pop_front();
            send_byte(1'b1, b);
         end
      end
   endtask

   initial begin
      int start;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = 8'h00;
      req_tuser    = 1'b0;
      items_sent   = 0;
      snd_idle_pct = 6;
      rcv_idle_pct = 59;
      sb = new(MAX_BYTES);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed cases
      send_byte(1'b0, ACK_BYTE);
      send_byte(1'b1, ACK_BYTE);
      send_text(1'b0, ":AB");
      send_byte(1'b0, CR_BYTE);
      send_text(1'b1, "x");            // line with no colon
      send_byte(1'b1, LF_BYTE);
      send_byte(1'b0, LF_BYTE);        // empty line
      send_text(1'b1, " \t:G #");      // blank before '#' stays
      send_text(1'b0, "  #");          // nothing left after trim
      send_text(1'b0, "a");
      send_byte(1'b0, ACK_BYTE);       // 0x06 on a non-empty buffer is data
      send_byte(1'b0, HASH_BYTE);
      send_byte(1'b1, 8'h00);
      send_byte(1'b1, 8'hFF);
      send_byte(1'b1, HASH_BYTE);
      send_text(1'b0, ":x \t");
      send_byte(1'b0, CR_BYTE);
      // hold off until everything has drained
      wait_drained();

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin snd_idle_pct = 6;  rcv_idle_pct = 59; end
            1: begin snd_idle_pct = 59; rcv_idle_pct = 6;  end
            default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
         endcase
         if (ph == 0) add_seq(1'b0, K_LONG_LINE);
         if (ph == 1) add_seq(1'b1, K_OVERFLOW);
         start = items_sent;
         while (items_sent - start < 10) begin
            add_seq(1'b0, rand_kind());
            add_seq(1'b1, rand_kind());
            flush_pending();
         end
         wait_drained();
      end

      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
